/* sv/brle_pkg.sv */
`timescale 1ns / 1ps

package brle_pkg;

  // Result queue geometry
  localparam int QDEPTH      = 8;
  localparam int MAX_RESULTS = 6;
  localparam int QCNT_W      = $clog2(QDEPTH + 1);
  localparam int PUSH_W      = $clog2(MAX_RESULTS + 1);

  // Run limits
  localparam logic [7:0] RUN_MAX8 = 8'd255;
  localparam logic [7:0] RUN_MAX4 = 8'd254;
  localparam logic [3:0] NIB_MASK = 4'hF;
  localparam logic [7:0] PIX_PER_BYTE = 8'd2;

  // Register map (word index of the APB address)
  typedef enum logic [1:0] {
    REG_NIBBLE_MODE = 2'd0,
    REG_ROW_BYTES   = 2'd1,
    REG_IMAGE_ROWS  = 2'd2
  } reg_idx_e;

  // One byte of the encoded stream
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       end_of_image;
  } res_t;

  // All results of one input transaction, in stream order
  typedef struct packed {
    logic [PUSH_W-1:0]       cnt;
    res_t [MAX_RESULTS-1:0]  data;
  } push_t;

endpackage

/* sv/brle_out_queue.sv */
`timescale 1ns / 1ps

module brle_out_queue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  brle_pkg::push_t               push_i,
  output logic                          out_valid,
  input  logic                          out_ready,
  output brle_pkg::res_t                head_o,
  output logic [brle_pkg::QCNT_W-1:0]   level_o
);

  brle_pkg::res_t                 slot_q [brle_pkg::QDEPTH];
  brle_pkg::res_t                 slot_d [brle_pkg::QDEPTH];
  logic [brle_pkg::QCNT_W-1:0]    cnt_q, cnt_d;
  logic [brle_pkg::QCNT_W-1:0]    base;
  logic                           pop;

  assign out_valid = (cnt_q != '0);
  assign pop       = out_valid && out_ready;
  assign head_o    = slot_q[0];
  assign level_o   = cnt_q;

  // Shift down on pop, then append the new transaction's results at the tail
  always_comb begin
    logic [brle_pkg::QCNT_W-1:0] off;
    base = cnt_q - brle_pkg::QCNT_W'(pop);
    for (int i = 0; i < brle_pkg::QDEPTH; i++) begin
      if (pop && (i < brle_pkg::QDEPTH - 1)) begin
        slot_d[i] = slot_q[(i + 1) % brle_pkg::QDEPTH];
      end else begin
        slot_d[i] = slot_q[i];
      end
      off = brle_pkg::QCNT_W'(i) - base;
      if ((brle_pkg::QCNT_W'(i) >= base) &&
          (off < brle_pkg::QCNT_W'(push_i.cnt))) begin
        slot_d[i] = push_i.data[off[brle_pkg::PUSH_W-1:0]];
      end
    end
    cnt_d = base + brle_pkg::QCNT_W'(push_i.cnt);
  end

  // Hold the queue contents
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < brle_pkg::QDEPTH; i++) begin
      slot_q[i] <= slot_d[i];
    end
  end

  // Track the fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

/* sv/bitmap_rle_row_encoder.sv */
`timescale 1ns / 1ps

// Run-length encoder for stored bitmap rows (8-bit or 4-bit encoded mode).
// Input channel: one stored image byte per transaction (pixel_byte_i), in
// row order, padding included. Output channel: one stream byte per
// transaction, with last_of_run_o on the final byte caused by an input byte
// and end_of_image_o on the closing byte of the end-of-bitmap marker.
// Configure nibble_mode, row_bytes and image_rows over the APB port while
// the block is idle; a zero size is taken as one.
// Each input byte is encoded in the cycle it is accepted and its results
// (zero to six bytes) land in an eight-entry registered output queue.
// Inside a run the block takes one byte per cycle while in_ready is high.
// in_ready is high while the queue holds two bytes or fewer: with the
// receiver ready, a row end of four or six bytes holds off the input until
// the queue drains to two bytes, and a two-byte run close stalls only when
// earlier bytes are still queued; a stalled receiver fills the queue and
// then holds off the input. Reset empties the queue, clears run and
// position state and loads the registers to 8-bit mode, one byte per row,
// one row.

module bitmap_rle_row_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input bytes
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  pixel_byte_i,
  // Encoded stream
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte_o,
  output logic        last_of_run_o,
  output logic        end_of_image_o
);

  logic        nibble_mode_q;
  logic [15:0] row_bytes_q, image_rows_q;
  logic [7:0]  held_q, held_d, run_q, run_d;
  logic [15:0] col_q, col_d, row_q, row_d;

  logic        in_acc, first, uneq, close, row_end, img_end;
  logic [7:0]  unit;
  logic [15:0] rb_m1, ir_m1;
  logic [brle_pkg::PUSH_W-1:0] n_res;
  brle_pkg::res_t [brle_pkg::MAX_RESULTS-1:0] res;
  brle_pkg::push_t push;
  brle_pkg::res_t  head;
  logic [brle_pkg::QCNT_W-1:0] level;

  // Configuration registers
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nibble_mode_q <= 1'b0;
      row_bytes_q   <= 16'd1;
      image_rows_q  <= 16'd1;
    end else if (psel && penable && pwrite && pready) begin
      unique case (brle_pkg::reg_idx_e'(paddr[3:2]))
        brle_pkg::REG_NIBBLE_MODE: nibble_mode_q <= pwdata[0];
        brle_pkg::REG_ROW_BYTES:   row_bytes_q   <= pwdata[15:0];
        brle_pkg::REG_IMAGE_ROWS:  image_rows_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (brle_pkg::reg_idx_e'(paddr[3:2]))
      brle_pkg::REG_NIBBLE_MODE: prdata = {31'd0, nibble_mode_q};
      brle_pkg::REG_ROW_BYTES:   prdata = {16'd0, row_bytes_q};
      brle_pkg::REG_IMAGE_ROWS:  prdata = {16'd0, image_rows_q};
      default:                   prdata = '0;
    endcase
  end

  // Accept while the queue has room for a full burst
  assign in_ready = (level <= brle_pkg::QCNT_W'(brle_pkg::QDEPTH - brle_pkg::MAX_RESULTS));
  assign in_acc   = in_valid && in_ready;

  // Run decision
  assign unit  = nibble_mode_q ? brle_pkg::PIX_PER_BYTE : 8'd1;
  assign first = (col_q == '0);
  assign uneq  = ((held_q & {4'd0, brle_pkg::NIB_MASK}) != {4'd0, held_q[7:4]});

  always_comb begin
    if (first) begin
      close = 1'b0;
    end else if (nibble_mode_q) begin
      close = uneq || (pixel_byte_i != held_q) || (run_q >= brle_pkg::RUN_MAX4);
    end else begin
      close = (pixel_byte_i != held_q) || (run_q >= brle_pkg::RUN_MAX8);
    end
  end

  assign held_d = (first || close) ? pixel_byte_i : held_q;
  assign run_d  = (first || close) ? unit : run_q + unit;

  // Row and image boundaries
  assign rb_m1   = (row_bytes_q == '0) ? '0 : row_bytes_q - 16'd1;
  assign ir_m1   = (image_rows_q == '0) ? '0 : image_rows_q - 16'd1;
  assign row_end = (col_q >= rb_m1);
  assign img_end = (row_q >= ir_m1);
  assign col_d   = row_end ? '0 : col_q + 16'd1;
  assign row_d   = !row_end ? row_q : (img_end ? '0 : row_q + 16'd1);

  // Assemble the result bytes of this transaction in stream order
  always_comb begin
    res = '0;
    if (close) begin
      res[0].out_byte = run_q;
      res[1].out_byte = held_q;
      if (row_end) begin
        res[2].out_byte     = run_d;
        res[3].out_byte     = held_d;
        res[5].out_byte     = {7'd0, img_end};
        res[5].end_of_image = img_end;
        res[5].last_of_run  = 1'b1;
        n_res = brle_pkg::PUSH_W'(6);
      end else begin
        res[1].last_of_run = 1'b1;
        n_res = brle_pkg::PUSH_W'(2);
      end
    end else if (row_end) begin
      res[0].out_byte     = run_d;
      res[1].out_byte     = held_d;
      res[3].out_byte     = {7'd0, img_end};
      res[3].end_of_image = img_end;
      res[3].last_of_run  = 1'b1;
      n_res = brle_pkg::PUSH_W'(4);
    end else begin
      n_res = '0;
    end
  end

  assign push.cnt  = in_acc ? n_res : '0;
  assign push.data = res;

  // Advance run and position state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      run_q  <= '0;
      col_q  <= '0;
      row_q  <= '0;
    end else if (in_acc) begin
      held_q <= held_d;
      run_q  <= run_d;
      col_q  <= col_d;
      row_q  <= row_d;
    end
  end

  brle_out_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head_o    (head),
    .level_o   (level)
  );

  assign out_byte_o     = head.out_byte;
  assign last_of_run_o  = head.last_of_run;
  assign end_of_image_o = head.end_of_image;

  // Queue never overfills
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    level <= brle_pkg::QCNT_W'(brle_pkg::QDEPTH))
    else $error("result queue overflow");

  // End-of-bitmap byte is a 1 closing its transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && end_of_image_o |-> (out_byte_o == 8'd1) && last_of_run_o)
    else $error("malformed end-of-bitmap byte");

  // A byte inside a run adds nothing to the queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !close && !row_end |=>
      level == $past(level) - brle_pkg::QCNT_W'($past(out_valid && out_ready)))
    else $error("result pushed inside a run");

  // Position resets to the row start after a row end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && row_end |=> col_q == '0)
    else $error("column not cleared at row end");

endmodule

/* test/bitmap_rle_row_encoder_test.sv */
`timescale 1ns / 1ps

module bitmap_rle_row_encoder_test;

  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE_CYCLES = 12;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam logic [3:0] UNUSED_REG_ADDR = 4'd12;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  pixel_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        last_of_run;
  logic        end_of_image;

  // Stimulus and scoreboard
  logic [7:0]     pixel_queue[$];
  brle_pkg::res_t expected_stream[$];
  int             send_idle_pct = 0;
  int             recv_stall_pct = 0;
  int             out_hold_cycles = 0;
  int             error_count = 0;
  int             cycle_count = 0;
  bit             in_fire = 1'b0;

  // Shadow registers and encoder state
  logic        nibble_cfg = 1'b0;
  logic [15:0] row_bytes_cfg = 16'd1;
  logic [15:0] image_rows_cfg = 16'd1;
  logic [7:0]  run_value = '0;
  logic [7:0]  run_count = '0;
  logic [15:0] col_count = '0;
  logic [15:0] rows_done = '0;

  bitmap_rle_row_encoder dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .pixel_byte_i   (pixel_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte_o     (out_byte),
    .last_of_run_o  (last_of_run),
    .end_of_image_o (end_of_image)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic void push_stream_byte(logic [7:0] value, logic eoi);
    expected_stream.push_back(brle_pkg::res_t'{out_byte: value, last_of_run: 1'b0,
                                               end_of_image: eoi});
  endfunction

  function automatic void push_run_pair();
    push_stream_byte(run_count, 1'b0);
    push_stream_byte(run_value, 1'b0);
  endfunction

  // Advance the encoder by one stored byte and queue the stream bytes it emits
  function automatic void encode_byte(logic [7:0] pix);
    logic [16:0]    row_len;
    logic [16:0]    row_total;
    logic [7:0]     step;
    logic           close_run;
    logic           last_row;
    int             start;
    brle_pkg::res_t tail;
    row_len = (row_bytes_cfg == 16'd0) ? 17'd1 : {1'b0, row_bytes_cfg};
    row_total = (image_rows_cfg == 16'd0) ? 17'd1 : {1'b0, image_rows_cfg};
    step = nibble_cfg ? brle_pkg::PIX_PER_BYTE : 8'd1;
    start = expected_stream.size();

    // Open a run at row start, else extend or close the held one
    if (col_count == 16'd0) begin
      run_value = pix;
      run_count = step;
    end else begin
      if (nibble_cfg) begin
        close_run = (run_value[3:0] != run_value[7:4]) || (pix != run_value) ||
                    (run_count >= brle_pkg::RUN_MAX4);
      end else begin
        close_run = (pix != run_value) || (run_count >= brle_pkg::RUN_MAX8);
      end
      if (close_run) begin
        push_run_pair();
        run_value = pix;
        run_count = step;
      end else begin
        run_count = run_count + step;
      end
    end

    // Flush the run and mark end of line or end of bitmap
    if ({1'b0, col_count} + 17'd1 >= row_len) begin
      last_row = ({1'b0, rows_done} + 17'd1 >= row_total);
      push_run_pair();
      push_stream_byte(8'd0, 1'b0);
      push_stream_byte({7'd0, last_row}, last_row);
      col_count = '0;
      rows_done = last_row ? 16'd0 : rows_done + 16'd1;
    end else begin
      col_count = col_count + 16'd1;
    end

    if (expected_stream.size() > start) begin
      tail = expected_stream.pop_back();
      tail.last_of_run = 1'b1;
      expected_stream.push_back(tail);
    end
  endfunction

  // Check results and predict on each input transaction
  always @(posedge clk_i) begin
    brle_pkg::res_t want;
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      in_fire = rst_ni && in_valid && in_ready;
      if (rst_ni && out_valid && out_ready) begin
        if (expected_stream.size() == 0) begin
          $error("unexpected result: out_byte %0h", out_byte);
          error_count++;
        end else begin
          want = expected_stream.pop_front();
          if (out_byte !== want.out_byte) begin
            $error("out_byte: expected %0h, actual %0h", want.out_byte, out_byte);
            error_count++;
          end
          if (last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0b, actual %0b", want.last_of_run, last_of_run);
            error_count++;
          end
          if (end_of_image !== want.end_of_image) begin
            $error("end_of_image: expected %0b, actual %0b", want.end_of_image,
                   end_of_image);
            error_count++;
          end
        end
      end
      if (in_fire) encode_byte(pixel_byte);
    end
  end

  // Hold the payload until taken, then offer the next byte or idle
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        pixel_byte <= pixel_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Stall the receiver at random, or for a long stretch on request
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= (out_hold_cycles == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(negedge clk_i) begin
    if (out_hold_cycles > 0) out_hold_cycles <= out_hold_cycles - 1;
  end

  task automatic write_reg(logic [3:0] addr, logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (addr[3:2])
      brle_pkg::REG_NIBBLE_MODE: nibble_cfg = value[0];
      brle_pkg::REG_ROW_BYTES:   row_bytes_cfg = value[15:0];
      brle_pkg::REG_IMAGE_ROWS:  image_rows_cfg = value[15:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (pixel_queue.size() != 0 || in_valid || expected_stream.size() != 0);
  endtask

  // Reprogram all registers once the block has gone quiet
  task automatic reconfigure(logic mode, logic [15:0] row_len, logic [15:0] rows);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_reg({brle_pkg::REG_NIBBLE_MODE, 2'b00}, {31'($urandom), mode});
    write_reg({brle_pkg::REG_ROW_BYTES, 2'b00}, {16'($urandom), row_len});
    write_reg({brle_pkg::REG_IMAGE_ROWS, 2'b00}, {16'($urandom), rows});
  endtask

  task automatic set_idling(int send_pct, int stall_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = stall_pct;
  endtask

  // Queue runs of repeated bytes, biased to equal nibbles for 4-bit mode
  task automatic queue_runs(int items, bit pairs);
    int         n;
    int         len;
    logic [7:0] value;
    logic [3:0] nib;
    n = 0;
    while (n < items) begin
      if (pairs && $urandom_range(3) != 0) begin
        nib = 4'($urandom);
        value = {nib, nib};
      end else begin
        value = 8'($urandom);
      end
      case ($urandom_range(9))
        0:       len = $urandom_range(8, 30);
        1, 2, 3: len = 1;
        default: len = $urandom_range(2, 5);
      endcase
      repeat (len) pixel_queue.push_back(value);
      n += len;
    end
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: default sizes, so every byte is a whole image
    pixel_queue.push_back(8'h00);
    pixel_queue.push_back(8'hFF);

    // Directed: 8-bit runs over two 4-byte rows
    reconfigure(1'b0, 16'd4, 16'd2);
    pixel_queue.push_back(8'hAA);
    pixel_queue.push_back(8'hAA);
    pixel_queue.push_back(8'h55);
    pixel_queue.push_back(8'h55);
    pixel_queue.push_back(8'h01);
    pixel_queue.push_back(8'h02);
    pixel_queue.push_back(8'h03);
    pixel_queue.push_back(8'h03);

    // Directed: pixel pairs, mixed nibbles stand alone even when repeated
    reconfigure(1'b1, 16'd3, 16'd1);
    pixel_queue.push_back(8'h77);
    pixel_queue.push_back(8'h77);
    pixel_queue.push_back(8'h12);
    pixel_queue.push_back(8'h34);
    pixel_queue.push_back(8'h34);
    pixel_queue.push_back(8'h34);
    pixel_queue.push_back(8'hF0);
    pixel_queue.push_back(8'h0F);
    pixel_queue.push_back(8'h0F);

    // Directed: zero sizes behave as one, unused register is ignored
    reconfigure(1'b0, 16'd0, 16'd0);
    write_reg(UNUSED_REG_ADDR, $urandom);
    pixel_queue.push_back(8'h80);
    pixel_queue.push_back(8'h7F);

    // No idling; long receiver hold-off, then a sender pause
    reconfigure(1'b0, 16'($urandom_range(1, 16)), 16'($urandom_range(1, 4)));
    set_idling(0, 0);
    queue_runs(25, 1'b0);
    out_hold_cycles = LONG_HOLD_CYCLES;
    wait_drained();
    queue_runs(15, 1'b0);

    // Sender idle most of the time
    reconfigure(1'b1, 16'($urandom_range(1, 9)), 16'($urandom_range(1, 3)));
    set_idling(82, 0);
    queue_runs(30, 1'b1);

    // Receiver stalling most of the time
    reconfigure(1'b0, 16'($urandom_range(2, 12)), 16'($urandom_range(1, 5)));
    set_idling(0, 82);
    queue_runs(30, 1'b0);

    // Both sides idling now and then
    reconfigure(1'b1, 16'($urandom_range(1, 12)), 16'($urandom_range(1, 4)));
    set_idling(17, 17);
    queue_runs(30, 1'b1);

    // Run limits: grow a pixel run to 254, switch to 8-bit mid-row so the
    // run reaches 255 and closes, then a pixel run closes at 254
    reconfigure(1'b1, 16'd130, 16'd1);
    repeat (127) pixel_queue.push_back(8'h66);
    reconfigure(1'b0, 16'd130, 16'd1);
    pixel_queue.push_back(8'h66);
    pixel_queue.push_back(8'h66);
    pixel_queue.push_back(8'($urandom));
    reconfigure(1'b1, 16'd130, 16'd1);
    repeat (129) pixel_queue.push_back(8'h66);
    pixel_queue.push_back(8'($urandom));

    // Largest sizes, then shrink mid-row so the row ends at once
    reconfigure(1'b0, 16'hFFFF, 16'hFFFF);
    set_idling(0, 0);
    queue_runs(15, 1'b0);
    reconfigure(1'b1, 16'd8, 16'd2);
    set_idling(17, 17);
    queue_runs(15, 1'b1);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/brle_pkg.sv
sv/brle_out_queue.sv
sv/bitmap_rle_row_encoder.sv
test/bitmap_rle_row_encoder_test.sv
